/* sv/zlbm_pkg.sv */
package zlbm_pkg;

	// Fixed field widths of one word on either side.
	localparam int unsigned UNIT_W   = 6;
	localparam int unsigned SLOT_W   = 11;
	localparam int unsigned IDX_W    = 16;
	localparam int unsigned ENTRY_W  = IDX_W + 1;
	localparam int unsigned LOC_W    = 48;
	localparam int unsigned BUCKET_W = 12;
	localparam int unsigned CFG_W    = 48;
	localparam int unsigned CIDX_W   = 3;
	localparam int unsigned IN_W     = 16;
	localparam int unsigned OUT_W    = 80;

	localparam logic [6:0]  MAX_UNITS          = 7'd64;
	localparam logic [10:0] MAX_SLOTS_PER_UNIT = 11'd1024;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_ERASE  = 2'd2,
		MODE_SCAN   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_RING_FULL = 3'd1,
		ST_WR_FAIL   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_LIVE_LEFT = 3'd4
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_NUM_UNITS    = 3'd0,
		CFG_BPU          = 3'd1,
		CFG_BUCKET_BYTES = 3'd2,
		CFG_ZONE_BYTES   = 3'd3,
		CFG_BASE_OFFSET  = 3'd4,
		CFG_CLEAN_LIMIT  = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_LK_READ,
		FSM_DIV,
		FSM_SCAN,
		FSM_W_DECIDE,
		FSM_W_CALC,
		FSM_W_COMMIT,
		FSM_MUL,
		FSM_SUM,
		FSM_OUT
	} fsm_t;

endpackage

/* sv/zoned_log_bucket_mapper.sv */
// Channel  | Direction | Contents
// s_*      | in        | one request word: mode in tuser, bucket and flags in tdata
// m_*      | out       | one result word per request, held in an output register
// cfg_*    | in        | register writes, taken on any edge with cfg_we high
//
// After reset the bucket table is swept to unmapped, one entry a cycle; no request is
// taken until the sweep is over. A lookup passes through table read, the divider,
// multiply, add and output, or goes from table read straight to output when the
// bucket is unmapped. A write passes through decide, calc, commit, multiply, add and
// output, after a walk of the table when a forced erase is asked for. A scan examines
// one table entry a cycle until it finds a live one or runs out, and erase-if-full
// goes straight to output. A new request is taken only in the idle state that follows,
// so one request is worked on at a time. A result waiting on m_tready does not stop
// the next request from being taken; it only holds back the following result.
module zoned_log_bucket_mapper #(
	parameter int unsigned NUM_BUCKETS = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [zlbm_pkg::IN_W-1:0]    s_tdata,   // bucket[11:0], must_write, device_ok
	input  logic [1:0]                   s_tuser,   // mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[2:0], location[50:3], found_bucket[62:51], new_bucket, reset_zone,
	// finish_zone, free_units[72:66], should_clean, zero fill
	output logic [zlbm_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         cfg_we,
	input  logic [zlbm_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [zlbm_pkg::CFG_W-1:0]   cfg_data
);
	import zlbm_pkg::*;

	localparam int unsigned ADDR_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int unsigned CNT_W     = $clog2(NUM_BUCKETS + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BUCKETS - 1);

	// Configuration registers.
	logic [6:0]  num_units_q;
	logic [10:0] bpu_q;
	logic [20:0] bucket_bytes_q;
	logic [40:0] zone_bytes_q;
	logic [47:0] base_q;
	logic [6:0]  clean_limit_q;
	logic [6:0]  units_eff;
	logic [10:0] bpu_eff;
	logic [6:0]  clean_eff;

	// Ring pointers.
	logic [UNIT_W-1:0] wu_q;
	logic [SLOT_W-1:0] ws_q;
	logic [UNIT_W-1:0] eu_q;
	logic              empty_q;
	logic              full;
	logic [16:0]       cap_q;
	logic [16:0]       erase_lo_q;

	// Request held while it is worked on.
	fsm_t              state_q, state_d;
	mode_t             mode_in;
	logic [BUCKET_W-1:0] bucket_in;
	logic              oor_in;
	logic [BUCKET_W-1:0] bucket_q;
	logic              ok_q;
	logic              check_q;

	// Result fields being built.
	status_t           status_q;
	logic [LOC_W-1:0]  loc_q;
	logic [BUCKET_W-1:0] found_q;
	logic              newb_q;
	logic              rz_q;
	logic              fz_q;

	// Shared datapath operands.
	logic [SLOT_W-1:0] op_rem_q;
	logic [UNIT_W-1:0] op_quot_q;
	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       prod_a_s1;
	logic [46:0]       prod_b_s1;
	logic [SLOT_W-1:0] ws_eff;
	logic [SLOT_W:0]   ws_next;

	// Table walk.
	logic [CNT_W-1:0]  scan_idx_q;
	logic              pipe_v_s1;
	logic [ADDR_W-1:0] pipe_idx_s1;
	logic              issuing;
	logic              live;
	logic              scan_hit;
	logic              scan_none;
	logic [ADDR_W-1:0] clr_q;

	// Table port and divider.
	logic [ADDR_W-1:0]  mem_addr;
	logic               mem_we;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;
	logic               unmapped;
	logic               div_start;
	logic [IDX_W-1:0]   div_quot;
	logic [SLOT_W-1:0]  div_rem;
	logic               div_done;

	logic [6:0]        free_cnt;
	logic [6:0]        gap;
	logic              in_fire;
	logic              out_load;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	function automatic logic [UNIT_W-1:0] next_unit(logic [UNIT_W-1:0] u, logic [6:0] n);
		logic [6:0] v;
		v = {1'b0, u} + 7'd1;
		return (v >= n) ? '0 : v[UNIT_W-1:0];
	endfunction

	// Registers are used clamped to their legal ranges.
	always_comb begin
		units_eff = (num_units_q == '0) ? 7'd1 :
			(num_units_q > MAX_UNITS) ? MAX_UNITS : num_units_q;
		bpu_eff   = (bpu_q == '0) ? 11'd1 :
			(bpu_q > MAX_SLOTS_PER_UNIT) ? MAX_SLOTS_PER_UNIT : bpu_q;
		clean_eff = (clean_limit_q == '0) ? 7'd1 : clean_limit_q;
		full      = (eu_q == wu_q) && !empty_q;
	end

	// Units free from the write pointer forward to the erase pointer.
	always_comb begin
		gap = '0;
		if (eu_q == wu_q) begin
			free_cnt = empty_q ? units_eff : 7'd0;
		end else if (eu_q > wu_q) begin
			gap      = {1'b0, eu_q - wu_q};
			free_cnt = (gap > units_eff) ? units_eff : gap;
		end else begin
			gap      = {1'b0, wu_q - eu_q};
			free_cnt = (gap >= units_eff) ? 7'd0 : 7'(units_eff - gap);
		end
	end

	always_comb begin
		mode_in   = mode_t'(s_tuser);
		bucket_in = s_tdata[BUCKET_W-1:0];
		oor_in    = 32'(bucket_in) >= NUM_BUCKETS;
		in_fire   = s_tvalid && s_tready;
		out_load  = (state_q == FSM_OUT) && (!m_tvalid_q || m_tready);
	end

	// An entry is live when valid and its slot lies inside the erase unit.
	always_comb begin
		live      = mem_rdata[IDX_W] && ({1'b0, mem_rdata[IDX_W-1:0]} >= erase_lo_q)
			&& ({1'b0, mem_rdata[IDX_W-1:0]} < erase_lo_q + {6'd0, bpu_eff});
		unmapped  = !mem_rdata[IDX_W] || ({1'b0, mem_rdata[IDX_W-1:0]} >= cap_q);
		issuing   = 32'(scan_idx_q) < NUM_BUCKETS;
		scan_hit  = pipe_v_s1 && live;
		scan_none = !issuing && !pipe_v_s1;
		ws_eff    = (ws_q >= bpu_eff) ? SLOT_W'(bpu_eff - 11'd1) : ws_q;
		ws_next   = ok_q ? {1'b0, ws_q} + 12'd1 : {1'b0, bpu_eff};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (in_fire) begin
					unique case (mode_in)
						MODE_LOOKUP: state_d = oor_in ? FSM_OUT : FSM_LK_READ;
						MODE_WRITE: begin
							if (oor_in) begin
								state_d = FSM_OUT;
							end else if (s_tdata[BUCKET_W] && full) begin
								state_d = FSM_SCAN;
							end else begin
								state_d = FSM_W_DECIDE;
							end
						end
						MODE_ERASE: state_d = FSM_OUT;
						MODE_SCAN:  state_d = oor_in ? FSM_OUT : FSM_SCAN;
						default:    state_d = FSM_OUT;
					endcase
				end
			end
			FSM_LK_READ:  state_d = unmapped ? FSM_OUT : FSM_DIV;
			FSM_DIV:      state_d = div_done ? FSM_MUL : FSM_DIV;
			FSM_SCAN: begin
				if (scan_hit) begin
					state_d = FSM_OUT;
				end else if (scan_none) begin
					state_d = check_q ? FSM_W_DECIDE : FSM_OUT;
				end
			end
			FSM_W_DECIDE: state_d = full ? FSM_OUT : FSM_W_CALC;
			FSM_W_CALC:   state_d = FSM_W_COMMIT;
			FSM_W_COMMIT: state_d = FSM_MUL;
			FSM_MUL:      state_d = FSM_SUM;
			FSM_SUM:      state_d = FSM_OUT;
			FSM_OUT:      state_d = out_load ? FSM_IDLE : FSM_OUT;
			default:      state_d = FSM_IDLE;
		endcase
	end

	// Outputs of the sequencer: table port, divider start, input ready.
	always_comb begin
		mem_addr  = '0;
		mem_we    = 1'b0;
		mem_wdata = '0;
		div_start = 1'b0;
		s_tready  = state_q == FSM_IDLE;
		unique case (state_q)
			FSM_CLEAR: begin
				mem_addr = clr_q;
				mem_we   = 1'b1;
			end
			FSM_IDLE:     mem_addr = ADDR_W'(bucket_in);
			FSM_LK_READ:  div_start = !unmapped;
			FSM_SCAN:     mem_addr = scan_idx_q[ADDR_W-1:0];
			FSM_W_COMMIT: begin
				mem_addr  = ADDR_W'(bucket_q);
				mem_we    = 1'b1;
				mem_wdata = ok_q ? {1'b1, idx_q} : '0;
			end
			default: ;
		endcase
	end

	zlbm_table #(
		.DEPTH  (NUM_BUCKETS),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	zlbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mem_rdata[IDX_W-1:0]),
		.divisor  (bpu_eff),
		.quot     (div_quot),
		.rem      (div_rem),
		.done     (div_done)
	);

	// Control state, configuration and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= FSM_CLEAR;
			clr_q          <= '0;
			num_units_q    <= 7'd64;
			bpu_q          <= 11'd1024;
			bucket_bytes_q <= 21'd4096;
			zone_bytes_q   <= 41'd4194304;
			base_q         <= '0;
			clean_limit_q  <= 7'd1;
			wu_q           <= '0;
			ws_q           <= '0;
			eu_q           <= '0;
			empty_q        <= 1'b1;
			pipe_v_s1      <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NUM_UNITS:    num_units_q    <= cfg_data[6:0];
					CFG_BPU:          bpu_q          <= cfg_data[10:0];
					CFG_BUCKET_BYTES: bucket_bytes_q <= cfg_data[20:0];
					CFG_ZONE_BYTES:   zone_bytes_q   <= cfg_data[40:0];
					CFG_BASE_OFFSET:  base_q         <= cfg_data[47:0];
					CFG_CLEAN_LIMIT:  clean_limit_q  <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == FSM_IDLE && in_fire && mode_in == MODE_ERASE && full) begin
				eu_q <= next_unit(eu_q, units_eff);
			end
			if (state_q == FSM_SCAN && check_q && !scan_hit && scan_none) begin
				eu_q <= next_unit(eu_q, units_eff);
			end
			if (state_q == FSM_W_CALC) begin
				ws_q <= ws_eff;
			end
			if (state_q == FSM_W_COMMIT) begin
				if (ws_next >= {1'b0, bpu_eff}) begin
					wu_q    <= next_unit(wu_q, units_eff);
					ws_q    <= '0;
					empty_q <= 1'b0;
				end else begin
					ws_q <= ws_next[SLOT_W-1:0];
				end
			end
			if (state_q == FSM_SCAN) begin
				pipe_v_s1 <= issuing && !scan_hit;
			end else begin
				pipe_v_s1 <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload: request fields, result fields and datapath operands.
	always_ff @(posedge clk) begin
		cap_q      <= 17'(units_eff * bpu_eff);
		erase_lo_q <= 17'(eu_q * bpu_eff);
		if (state_q == FSM_IDLE && in_fire) begin
			bucket_q   <= bucket_in;
			ok_q       <= s_tdata[BUCKET_W+1];
			check_q    <= mode_in == MODE_WRITE;
			scan_idx_q <= (mode_in == MODE_SCAN) ? CNT_W'(bucket_in) : '0;
			status_q   <= oor_in ? ST_NOT_FOUND : ST_OK;
			loc_q      <= '0;
			found_q    <= '0;
			newb_q     <= oor_in && mode_in == MODE_LOOKUP;
			rz_q       <= 1'b0;
			fz_q       <= 1'b0;
		end
		unique case (state_q)
			FSM_LK_READ: begin
				if (unmapped) begin
					status_q <= ST_NOT_FOUND;
					newb_q   <= 1'b1;
				end
			end
			FSM_DIV: begin
				op_rem_q  <= div_rem;
				op_quot_q <= div_quot[UNIT_W-1:0];
			end
			FSM_SCAN: begin
				if (issuing) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
				pipe_idx_s1 <= scan_idx_q[ADDR_W-1:0];
				if (scan_hit) begin
					status_q <= check_q ? ST_LIVE_LEFT : ST_OK;
					found_q  <= check_q ? '0 : BUCKET_W'(pipe_idx_s1);
				end else if (scan_none && !check_q) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			FSM_W_DECIDE: begin
				if (full) begin
					status_q <= ST_RING_FULL;
				end
			end
			FSM_W_CALC: begin
				idx_q     <= IDX_W'(wu_q * bpu_eff + {7'd0, ws_eff});
				op_rem_q  <= ws_eff;
				op_quot_q <= wu_q;
				rz_q      <= ws_eff == '0;
			end
			FSM_W_COMMIT: begin
				fz_q <= ws_next >= {1'b0, bpu_eff};
				if (!ok_q) begin
					status_q <= ST_WR_FAIL;
				end
			end
			FSM_MUL: begin
				prod_a_s1 <= 32'(op_rem_q * bucket_bytes_q);
				prod_b_s1 <= 47'(op_quot_q * zone_bytes_q);
			end
			FSM_SUM: begin
				loc_q <= LOC_W'(base_q + {16'd0, prod_a_s1} + {1'b0, prod_b_s1});
			end
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q <= {6'd0, (free_cnt <= clean_eff), free_cnt, fz_q, rz_q, newb_q,
				found_q, loc_q, status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* sv/zlbm_table.sv */
module zlbm_table #(
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = 12
) (
	input  logic                         clk,
	input  logic [ADDR_W-1:0]            addr,
	input  logic                         we,
	input  logic [zlbm_pkg::ENTRY_W-1:0] wdata,
	output logic [zlbm_pkg::ENTRY_W-1:0] rdata
);
	import zlbm_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];

	// Single port, read data registered; a write returns the old entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* sv/zlbm_div.sv */
module zlbm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [zlbm_pkg::IDX_W-1:0]  dividend,
	input  logic [zlbm_pkg::SLOT_W-1:0] divisor,
	output logic [zlbm_pkg::IDX_W-1:0]  quot,
	output logic [zlbm_pkg::SLOT_W-1:0] rem,
	output logic                        done
);
	import zlbm_pkg::*;

	logic [IDX_W-1:0]  dvd_q;
	logic [SLOT_W-1:0] rem_q;
	logic [SLOT_W-1:0] dsr_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [SLOT_W:0]   shifted;
	logic              take;

	// Restoring division, one quotient bit a cycle.
	always_comb begin
		shifted = {rem_q, dvd_q[IDX_W-1]};
		take    = shifted >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(IDX_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[IDX_W-2:0], take};
			rem_q <= take ? SLOT_W'(shifted - {1'b0, dsr_q}) : shifted[SLOT_W-1:0];
		end
	end

	assign quot = dvd_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

/* verif/testbench.sv */
module testbench;
	import zlbm_pkg::*;

	// One request word as the sender sees it.
	typedef struct {
		mode_t       mode;
		logic [11:0] bucket;
		logic        must_write;
		logic        device_ok;
	} request_t;

	// One result word, split into its fields.
	typedef struct {
		logic [2:0]  status;
		logic [47:0] location;
		logic [11:0] found_bucket;
		logic        new_bucket;
		logic        reset_zone;
		logic        finish_zone;
		logic [6:0]  free_units;
		logic        should_clean;
	} result_t;

	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned NUM_BUCKETS_TB = 4096;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;
	logic [1:0]         s_tuser = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;
	logic               cfg_we = 1'b0;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	zoned_log_bucket_mapper dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the mapper: bucket table, pointers and registers.
	logic [16:0] slot_map [NUM_BUCKETS_TB];
	int unsigned  wr_unit, wr_slot, er_unit;
	bit           ring_is_empty;
	logic [6:0]   r_units;
	logic [10:0]  r_bpu;
	logic [20:0]  r_bucket_bytes;
	logic [40:0]  r_zone_bytes;
	logic [47:0]  r_base;
	logic [6:0]   r_clean_limit;

	request_t     pending_requests [$];
	result_t      owed_results [$];
	int unsigned  n_bad = 0;
	bit           idling_on = 1'b1;
	int unsigned  quiet_cycles = 0;

	function automatic int unsigned units_used();
		if (r_units < 1) return 1;
		if (r_units > MAX_UNITS) return MAX_UNITS;
		return r_units;
	endfunction

	function automatic int unsigned bpu_used();
		if (r_bpu < 1) return 1;
		if (r_bpu > MAX_SLOTS_PER_UNIT) return MAX_SLOTS_PER_UNIT;
		return r_bpu;
	endfunction

	function automatic int unsigned step_unit(int unsigned u);
		return (u + 1 >= units_used()) ? 0 : u + 1;
	endfunction

	function automatic bit ring_is_full();
		return er_unit == wr_unit && !ring_is_empty;
	endfunction

	function automatic int unsigned units_free();
		int unsigned n, d;
		n = units_used();
		if (er_unit == wr_unit) return ring_is_empty ? n : 0;
		if (er_unit > wr_unit) begin
			d = er_unit - wr_unit;
			return d > n ? n : d;
		end
		d = wr_unit - er_unit;
		return d >= n ? 0 : n - d;
	endfunction

	function automatic logic [47:0] byte_location(longint unsigned slot);
		longint unsigned bpu, loc;
		bpu = bpu_used();
		loc = longint'(r_base) + (slot % bpu) * longint'(r_bucket_bytes)
			+ (slot / bpu) * longint'(r_zone_bytes);
		return loc[47:0];
	endfunction

	function automatic bit held_in_erase_unit(logic [16:0] entry);
		if (!entry[16]) return 1'b0;
		return (int'(entry[15:0]) / bpu_used()) == er_unit;
	endfunction

	// Applies one request to our copy of the mapper and works out its result.
	function automatic result_t map_request(request_t rq);
		result_t     r;
		int unsigned bpu, slot;
		bit          blocked, live;
		logic [16:0] entry;
		int unsigned fu, lim;
		r = '{default: '0};
		bpu = bpu_used();
		case (rq.mode)
			MODE_LOOKUP: begin
				entry = slot_map[rq.bucket];
				if (!entry[16] || int'(entry[15:0]) >= units_used() * bpu) begin
					r.status = ST_NOT_FOUND;
					r.new_bucket = 1'b1;
				end else begin
					r.location = byte_location(entry[15:0]);
				end
			end
			MODE_WRITE: begin
				blocked = 1'b0;
				if (rq.must_write && ring_is_full()) begin
					live = 1'b0;
					for (int i = 0; i < NUM_BUCKETS_TB; i++)
						if (held_in_erase_unit(slot_map[i])) begin
							live = 1'b1;
							break;
						end
					if (live) begin
						r.status = ST_LIVE_LEFT;
						blocked = 1'b1;
					end else begin
						er_unit = step_unit(er_unit);
					end
				end
				if (!blocked && ring_is_full()) begin
					r.status = ST_RING_FULL;
					blocked = 1'b1;
				end
				if (!blocked) begin
					// A slot left past the end of a shrunken unit becomes its last slot.
					if (wr_slot >= bpu) wr_slot = bpu - 1;
					r.reset_zone = (wr_slot == 0);
					slot = wr_unit * bpu + wr_slot;
					r.location = byte_location(slot);
					if (rq.device_ok) begin
						slot_map[rq.bucket] = {1'b1, slot[15:0]};
						wr_slot++;
					end else begin
						// A failed write abandons the rest of the unit.
						slot_map[rq.bucket] = '0;
						wr_slot = bpu;
						r.status = ST_WR_FAIL;
					end
					if (wr_slot >= bpu) begin
						r.finish_zone = 1'b1;
						wr_unit = step_unit(wr_unit);
						wr_slot = 0;
						ring_is_empty = 1'b0;
					end
				end
			end
			MODE_ERASE: begin
				if (ring_is_full()) er_unit = step_unit(er_unit);
			end
			default: begin
				r.status = ST_NOT_FOUND;
				for (int i = rq.bucket; i < NUM_BUCKETS_TB; i++)
					if (held_in_erase_unit(slot_map[i])) begin
						r.status = ST_OK;
						r.found_bucket = 12'(i);
						break;
					end
			end
		endcase
		fu = units_free();
		lim = (r_clean_limit < 1) ? 1 : r_clean_limit;
		r.free_units = 7'(fu);
		r.should_clean = (fu <= lim);
		return r;
	endfunction

	// Sender: takes words from the pending queue, idling now and then.
	always @(posedge clk or negedge arst_n) begin
		request_t rq;
		bit       taken;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			taken = s_tvalid && s_tready;
			if (taken) begin
				rq.mode = mode_t'(s_tuser);
				rq.bucket = s_tdata[11:0];
				rq.must_write = s_tdata[12];
				rq.device_ok = s_tdata[13];
				owed_results.push_back(map_request(rq));
			end
			if (taken || !s_tvalid) begin
				if (pending_requests.size() != 0 &&
						!(idling_on && $urandom_range(99) < 15)) begin
					rq = pending_requests.pop_front();
					s_tuser <= rq.mode;
					s_tdata <= {2'b00, rq.device_ok, rq.must_write, rq.bucket};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls at random and checks every word against the oldest result owed.
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		bit      ok;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(idling_on && $urandom_range(99) < 15);
			if (m_tvalid && m_tready) begin
				got.status       = m_tdata[2:0];
				got.location     = m_tdata[50:3];
				got.found_bucket = m_tdata[62:51];
				got.new_bucket   = m_tdata[63];
				got.reset_zone   = m_tdata[64];
				got.finish_zone  = m_tdata[65];
				got.free_units   = m_tdata[72:66];
				got.should_clean = m_tdata[73];
				if (owed_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) $display("result word with nothing owed: %h", m_tdata);
				end else begin
					want = owed_results.pop_front();
					ok = got.status == want.status && got.location == want.location &&
						got.found_bucket == want.found_bucket &&
						got.new_bucket == want.new_bucket &&
						got.reset_zone == want.reset_zone &&
						got.finish_zone == want.finish_zone &&
						got.free_units == want.free_units &&
						got.should_clean == want.should_clean;
					if (!ok) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"mismatch: expected st=%0d loc=%h fb=%0d nb=%b rz=%b fz=%b ",
								"fu=%0d sc=%b, got st=%0d loc=%h fb=%0d nb=%b rz=%b fz=%b fu=%0d sc=%b"},
								want.status, want.location, want.found_bucket, want.new_bucket,
								want.reset_zone, want.finish_zone, want.free_units,
								want.should_clean, got.status, got.location, got.found_bucket,
								got.new_bucket, got.reset_zone, got.finish_zone,
								got.free_units, got.should_clean);
					end
				end
			end
		end
	end

	// Watchdog: counts cycles in which no word moves on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL zoned_log_bucket_mapper");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [47:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_NUM_UNITS:    r_units = value[6:0];
			CFG_BPU:          r_bpu = value[10:0];
			CFG_BUCKET_BYTES: r_bucket_bytes = value[20:0];
			CFG_ZONE_BYTES:   r_zone_bytes = value[40:0];
			CFG_BASE_OFFSET:  r_base = value;
			default:          r_clean_limit = value[6:0];
		endcase
	endtask

	task automatic push_request(mode_t m, int unsigned b, bit mw, bit ok);
		request_t rq;
		rq.mode = m;
		rq.bucket = 12'(b);
		rq.must_write = mw;
		rq.device_ok = ok;
		pending_requests.push_back(rq);
	endtask

	// Random traffic: mostly writes and lookups over a small set of buckets, so that
	// the ring fills, buckets are overwritten and forced erases find dead units.
	task automatic push_random(int unsigned count, int unsigned hot);
		int unsigned pick, b;
		mode_t       m;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 47) m = MODE_WRITE;
			else if (pick < 80) m = MODE_LOOKUP;
			else if (pick < 93) m = MODE_ERASE;
			else m = MODE_SCAN;
			b = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(hot);
			// Scans that start late stay short when nothing is held in the erase unit.
			if (m == MODE_SCAN && $urandom_range(1)) b = 4095 - $urandom_range(hot);
			push_request(m, b, $urandom_range(1) != 0, $urandom_range(9) != 0);
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_tvalid || owed_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [47:0] bb, zb, base;
		logic [47:0] nu, bpu, cl;
		int unsigned items;
		for (int i = 0; i < NUM_BUCKETS_TB; i++) slot_map[i] = '0;
		wr_unit = 0;
		wr_slot = 0;
		er_unit = 0;
		ring_is_empty = 1'b1;
		r_units = 64;
		r_bpu = 1024;
		r_bucket_bytes = 4096;
		r_zone_bytes = 4194304;
		r_base = 0;
		r_clean_limit = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening under the reset settings: unmapped lookup, good writes at both ends of
		// the bucket range, a failed write at the top end, scans and an erase on a non-full ring.
		push_request(MODE_LOOKUP, 0, 0, 1);
		push_request(MODE_WRITE, 0, 0, 1);
		push_request(MODE_LOOKUP, 0, 0, 1);
		push_request(MODE_WRITE, 4095, 1, 0);
		push_request(MODE_LOOKUP, 4095, 0, 1);
		push_request(MODE_WRITE, 4095, 0, 1);
		push_request(MODE_LOOKUP, 4095, 0, 1);
		push_request(MODE_SCAN, 0, 0, 1);
		push_request(MODE_SCAN, 4095, 0, 1);
		push_request(MODE_ERASE, 0, 0, 1);
		push_random(200, 63);

		for (int p = 1; p <= 8; p++) begin
			// The sender holds back here until every result owed has come back.
			wait_drained();
			repeat (10) @(posedge clk);
			bb = 48'({$urandom, $urandom});
			zb = 48'({$urandom, $urandom});
			base = 48'({$urandom, $urandom});
			items = 260;
			idling_on = 1'b1;
			case (p)
				1: begin nu = 1; bpu = 1; cl = 0; items = 40; end
				2: begin nu = 2; bpu = 3; cl = 2; idling_on = 1'b0; end
				3: begin nu = 0; bpu = 0; cl = 127; items = 40; end
				4: begin nu = 127; bpu = 1; cl = 64; end
				5: begin nu = 3; bpu = 5; cl = 1; bb = '1; zb = '1; base = '1; end
				6: begin nu = 5; bpu = 2; cl = 3; end
				7: begin nu = 64; bpu = 2047; cl = 64; bb = 1; zb = 1; base = 0; end
				default: begin nu = 2; bpu = 4; cl = 1; end
			endcase
			write_reg(CFG_NUM_UNITS, nu);
			write_reg(CFG_BPU, bpu);
			write_reg(CFG_BUCKET_BYTES, bb);
			write_reg(CFG_ZONE_BYTES, zb);
			write_reg(CFG_BASE_OFFSET, base);
			write_reg(CFG_CLEAN_LIMIT, cl);
			@(posedge clk);
			cfg_we <= 1'b0;
			if (p == 1) begin
				// Single unit: the ring is full after one write, live buckets block
				// a forced erase, and an erase-if-full wraps back onto the same unit.
				push_request(MODE_WRITE, 7, 0, 1);
				push_request(MODE_WRITE, 8, 0, 1);
				push_request(MODE_WRITE, 8, 1, 1);
				push_request(MODE_ERASE, 0, 0, 1);
				push_request(MODE_SCAN, 0, 0, 1);
				push_request(MODE_LOOKUP, 7, 0, 1);
			end
			push_random(items, (p == 4) ? 127 : 15);
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (n_bad == 0) begin
			$display("PASS zoned_log_bucket_mapper");
		end else begin
			$display("FAIL zoned_log_bucket_mapper");
		end
		$finish;
	end

endmodule
